[rtl/core/acde_pkg.sv]
// ----------------------------------------------------------------------------
// acde_pkg
// Shared types and constants of the accumulator processor: field widths,
// function codes, opcodes and sequencer states.
// ----------------------------------------------------------------------------
package acde_pkg;

  // field widths
  localparam int unsigned WORD_W  = 16;
  localparam int unsigned ADDR_W  = 12;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned OP_W    = 4;

  // default memory depth in words
  localparam int unsigned MEM_WORDS_DEF = 4096;

  // function codes of an input beat
  typedef enum logic [FUNC_W-1:0] {
    FN_WRITE = 2'd0,
    FN_EXEC  = 2'd1,
    FN_READ  = 2'd2
  } func_t;

  // instruction opcodes, bits 15..12 of the instruction word
  typedef enum logic [OP_W-1:0] {
    OP_LODD = 4'h0,
    OP_STOD = 4'h1,
    OP_ADDD = 4'h2,
    OP_SUBD = 4'h3,
    OP_JPOS = 4'h4,
    OP_JZER = 4'h5,
    OP_JUMP = 4'h6,
    OP_LOCO = 4'h7,
    OP_LODL = 4'h8,
    OP_STOL = 4'h9,
    OP_ADDL = 4'hA,
    OP_SUBL = 4'hB,
    OP_JNEG = 4'hC,
    OP_JNZE = 4'hD,
    OP_CALL = 4'hE,
    OP_PSHI = 4'hF
  } opcode_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RDAT,
    ST_FETCH,
    ST_OPER,
    ST_PUB
  } state_t;

endpackage

[rtl/core/acde_ram.sv]
// ----------------------------------------------------------------------------
// acde_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module acde_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, held while not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/core/accumulator_cpu_direct_executor.sv]
// ----------------------------------------------------------------------------
// accumulator_cpu_direct_executor
// Accumulator processor with a word memory: one step beat writes a word,
// reads a word or executes one instruction, and gives one result beat.
// ----------------------------------------------------------------------------
//
//  channel  handshake                  payload
//  -------  -------------------------  --------------------------------------
//  step     step_valid / step_stall    func, access_addr, write_value
//  result   result_valid / result_stall program_counter_out, accumulator_out,
//                                      stack_pointer_out, instruction_out,
//                                      halted, read_value, executed_count
//
//  write, halted execute and unused function code finish in the idle state
//  read: a memory read; execute: instruction fetch, operand read, then
//  execute with write-back
//  result beats sit in an output register; the next step beat is taken while
//  one waits, and a finished item is held back only while that register is full
//  rst is synchronous; it clears the registers, memory contents stay undefined
//
module accumulator_cpu_direct_executor #(
  parameter int unsigned MEM_WORDS = acde_pkg::MEM_WORDS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step_valid,
  output logic                          step_stall,
  input  logic [acde_pkg::FUNC_W-1:0]   func,
  input  logic [acde_pkg::ADDR_W-1:0]   access_addr,
  input  logic [acde_pkg::WORD_W-1:0]   write_value,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic [acde_pkg::WORD_W-1:0]   program_counter_out,
  output logic [acde_pkg::WORD_W-1:0]   accumulator_out,
  output logic [acde_pkg::WORD_W-1:0]   stack_pointer_out,
  output logic [acde_pkg::WORD_W-1:0]   instruction_out,
  output logic                          halted,
  output logic [acde_pkg::WORD_W-1:0]   read_value,
  output logic [acde_pkg::COUNT_W-1:0]  executed_count
);
  import acde_pkg::*;

  localparam int unsigned AW = $clog2(MEM_WORDS);
  localparam logic [ADDR_W:0] ADDR_LIM = (ADDR_W + 1)'(MEM_WORDS);
  localparam logic [WORD_W:0] PC_LIM   = (WORD_W + 1)'(MEM_WORDS);

  // sequencer and architectural registers
  state_t               state, state_next;
  logic [WORD_W-1:0]    pc, pc_next;
  logic [WORD_W-1:0]    ac, ac_next;
  logic [WORD_W-1:0]    sp, sp_next;
  logic [WORD_W-1:0]    ir, ir_next;
  logic [COUNT_W-1:0]   count, count_next;
  logic                 rd_ok, rd_ok_next;
  logic                 pend_halt;
  logic [WORD_W-1:0]    pend_rd;

  // completion and result of the current item
  logic                 done;
  logic                 out_free;
  logic                 res_halt;
  logic [WORD_W-1:0]    res_rd;

  // memory port
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [WORD_W-1:0]    mem_wdata;
  logic                 mem_re;
  logic [AW-1:0]        mem_raddr;
  logic [WORD_W-1:0]    mem_rdata;

  // decode helpers
  opcode_t              fetch_op;
  logic [ADDR_W-1:0]    fetch_oper_addr;
  opcode_t              op;
  logic [ADDR_W-1:0]    arg;
  logic [ADDR_W-1:0]    local_addr;
  logic [ADDR_W-1:0]    sp_dec;
  logic [WORD_W-1:0]    opnd;
  logic [WORD_W-1:0]    pc_inc;
  logic                 pc_ok;

  function automatic logic in_mem(input logic [ADDR_W-1:0] a);
    return {1'b0, a} < ADDR_LIM;
  endfunction

  acde_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MEM_WORDS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  assign step_stall = (state != ST_IDLE);
  assign out_free   = !result_valid || !result_stall;
  assign pc_ok      = {1'b0, pc} < PC_LIM;

  // operand address of the word just fetched
  assign fetch_op = opcode_t'(mem_rdata[WORD_W-1 -: OP_W]);
  always_comb begin
    unique case (fetch_op) inside
      OP_LODL, OP_ADDL, OP_SUBL: fetch_oper_addr = sp[ADDR_W-1:0] + mem_rdata[ADDR_W-1:0];
      OP_PSHI:                   fetch_oper_addr = ac[ADDR_W-1:0];
      default:                   fetch_oper_addr = mem_rdata[ADDR_W-1:0];
    endcase
  end

  // fields of the instruction under execution
  assign op         = opcode_t'(ir[WORD_W-1 -: OP_W]);
  assign arg        = ir[ADDR_W-1:0];
  assign local_addr = sp[ADDR_W-1:0] + arg;
  assign sp_dec     = sp[ADDR_W-1:0] - ADDR_W'(1);
  assign opnd       = rd_ok ? mem_rdata : '0;
  assign pc_inc     = pc + WORD_W'(1);

  // datapath and memory control
  always_comb begin
    pc_next    = pc;
    ac_next    = ac;
    sp_next    = sp;
    ir_next    = ir;
    count_next = count;
    rd_ok_next = rd_ok;
    mem_we     = 1'b0;
    mem_waddr  = access_addr[AW-1:0];
    mem_wdata  = write_value;
    mem_re     = 1'b0;
    mem_raddr  = access_addr[AW-1:0];
    done       = 1'b0;
    res_halt   = 1'b0;
    res_rd     = '0;
    unique case (state)
      ST_IDLE: begin
        if (step_valid) begin
          case (func_t'(func))
            FN_WRITE: begin
              mem_we = in_mem(access_addr);
              done   = 1'b1;
            end
            FN_EXEC: begin
              if (pc_ok) begin
                mem_re    = 1'b1;
                mem_raddr = pc[AW-1:0];
              end else begin
                done     = 1'b1;
                res_halt = 1'b1;
              end
            end
            FN_READ: begin
              mem_re     = 1'b1;
              rd_ok_next = in_mem(access_addr);
            end
            default: done = 1'b1;
          endcase
        end
      end
      ST_RDAT: begin
        done   = 1'b1;
        res_rd = rd_ok ? mem_rdata : '0;
      end
      ST_FETCH: begin
        ir_next    = mem_rdata;
        mem_re     = 1'b1;
        mem_raddr  = fetch_oper_addr[AW-1:0];
        rd_ok_next = in_mem(fetch_oper_addr);
      end
      ST_OPER: begin
        done       = 1'b1;
        pc_next    = pc_inc;
        count_next = count + COUNT_W'(1);
        mem_wdata  = ac;
        unique case (op) inside
          OP_LODD, OP_LODL: ac_next = opnd;
          OP_ADDD, OP_ADDL: ac_next = ac + opnd;
          OP_SUBD, OP_SUBL: ac_next = ac - opnd;
          OP_STOD: begin
            mem_we    = in_mem(arg);
            mem_waddr = arg[AW-1:0];
          end
          OP_STOL: begin
            mem_we    = in_mem(local_addr);
            mem_waddr = local_addr[AW-1:0];
          end
          OP_JPOS: if (ac != '0 && !ac[WORD_W-1]) pc_next = WORD_W'(arg);
          OP_JZER: if (ac == '0) pc_next = WORD_W'(arg);
          OP_JUMP: pc_next = WORD_W'(arg);
          OP_LOCO: ac_next = WORD_W'(arg);
          OP_JNEG: if (ac[WORD_W-1]) pc_next = WORD_W'(arg);
          OP_JNZE: if (ac != '0) pc_next = WORD_W'(arg);
          OP_CALL: begin
            sp_next   = WORD_W'(sp_dec);
            mem_we    = in_mem(sp_dec);
            mem_waddr = sp_dec[AW-1:0];
            mem_wdata = pc_inc;
            pc_next   = WORD_W'(arg);
          end
          OP_PSHI: begin
            sp_next   = WORD_W'(sp_dec);
            mem_we    = in_mem(sp_dec);
            mem_waddr = sp_dec[AW-1:0];
            mem_wdata = opnd;
          end
          default: ;
        endcase
      end
      ST_PUB: begin
        done     = 1'b1;
        res_halt = pend_halt;
        res_rd   = pend_rd;
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (step_valid && !done) begin
          state_next = (func_t'(func) == FN_EXEC) ? ST_FETCH : ST_RDAT;
        end
      end
      ST_FETCH: state_next = ST_OPER;
      default:  state_next = ST_IDLE;
    endcase
    if (done && !out_free) begin
      state_next = ST_PUB;
    end
  end

  // control and architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      pc           <= '0;
      ac           <= '0;
      sp           <= '0;
      ir           <= '0;
      count        <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      pc    <= pc_next;
      ac    <= ac_next;
      sp    <= sp_next;
      ir    <= ir_next;
      count <= count_next;
      if (done && out_free) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // result register and held result of a blocked item
  always_ff @(posedge clk) begin
    rd_ok <= rd_ok_next;
    if (done && out_free) begin
      program_counter_out <= pc_next;
      accumulator_out     <= ac_next;
      stack_pointer_out   <= sp_next;
      instruction_out     <= ir_next;
      halted              <= res_halt;
      read_value          <= res_rd;
      executed_count      <= count_next;
    end
    if (done && !out_free) begin
      pend_halt <= res_halt;
      pend_rd   <= res_rd;
    end
  end

endmodule

[rtl/core/acde_checker.sv]
// ----------------------------------------------------------------------------
// acde_checker
// Port-level checks of the accumulator processor, bound to the top level.
// ----------------------------------------------------------------------------
module acde_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          result_valid,
  input logic                          result_stall,
  input logic [acde_pkg::WORD_W-1:0]   program_counter_out,
  input logic                          halted,
  input logic [acde_pkg::WORD_W-1:0]   read_value,
  input logic [acde_pkg::COUNT_W-1:0]  executed_count
);
  import acde_pkg::*;

  logic [WORD_W-1:0]  last_pc;
  logic [COUNT_W-1:0] last_count;

  // state shown by the last delivered beat
  always_ff @(posedge clk) begin
    if (rst) begin
      last_pc    <= '0;
      last_count <= '0;
    end else if (result_valid && !result_stall) begin
      last_pc    <= program_counter_out;
      last_count <= executed_count;
    end
  end

  // no result beat right after reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // a stalled result beat holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(executed_count)
      && $stable(program_counter_out))
    else $error("stalled result beat changed");

  // a halted step changes nothing and reads nothing
  a_halt_still: assert property (@(posedge clk) disable iff (rst)
    result_valid && halted |-> executed_count == last_count
      && program_counter_out == last_pc && read_value == '0)
    else $error("halted step changed state");

  // each beat executes at most one instruction
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> executed_count == last_count
      || executed_count == last_count + COUNT_W'(1))
    else $error("executed count jumped");

endmodule

bind accumulator_cpu_direct_executor acde_checker u_acde_checker (
  .clk                 (clk),
  .rst                 (rst),
  .result_valid        (result_valid),
  .result_stall        (result_stall),
  .program_counter_out (program_counter_out),
  .halted              (halted),
  .read_value          (read_value),
  .executed_count      (executed_count)
);
